@@ hw/rtl/swm_pkg.sv @@
`timescale 1ns / 1ps

package swm_pkg;

  localparam int SAMPLE_W = 32;
  localparam int WSIZE_W  = 7;

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic [WSIZE_W-1:0]         wsize_t;

  localparam wsize_t WSIZE_RESET = wsize_t'(3);

  // Status one cell shows to its neighbors during an update
  typedef struct packed {
    logic valid;  // cell holds a window sample
    logic up;     // value above the incoming sample: moves one place up
    logic down;   // value above the evicted sample: moves one place down
    logic eq;     // value equals the evicted sample
  } cell_stat_t;

endpackage

@@ hw/rtl/swm_sample_if.sv @@
`timescale 1ns / 1ps

interface swm_sample_if;
  logic             valid;
  logic             ready;
  swm_pkg::sample_t sample;

  modport source (output valid, output sample, input ready);
  modport sink (input valid, input sample, output ready);
endinterface

@@ hw/rtl/swm_median_if.sv @@
`timescale 1ns / 1ps

interface swm_median_if;
  logic             valid;
  logic             ready;
  swm_pkg::sample_t median;

  modport source (output valid, output median, input ready);
  modport sink (input valid, input median, output ready);
endinterface

@@ hw/rtl/swm_cfg_if.sv @@
`timescale 1ns / 1ps

interface swm_cfg_if;
  logic            valid;
  logic            ready;
  swm_pkg::wsize_t window_size;

  modport source (output valid, output window_size, input ready);
  modport sink (input valid, input window_size, output ready);
endinterface

@@ hw/rtl/swm_ram.sv @@
`timescale 1ns / 1ps

module swm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                                      clk,
  input  logic                                      wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                          wr_data,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                          rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

@@ hw/rtl/swm_cell.sv @@
`timescale 1ns / 1ps

module swm_cell (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   clear,
  input  logic                   step,
  input  logic                   full,
  input  swm_pkg::sample_t       sample,
  input  swm_pkg::sample_t       old_sample,
  input  swm_pkg::cell_stat_t    left_stat,
  input  swm_pkg::sample_t       left_val,
  input  swm_pkg::cell_stat_t    right_stat,
  input  swm_pkg::sample_t       right_val,
  output swm_pkg::cell_stat_t    stat,
  output swm_pkg::sample_t       val
);

  logic                valid;
  swm_pkg::sample_t    val_next;
  logic                valid_next;
  logic                removed;
  logic                left_removed;
  logic                stays;

  // Flags seen by the neighbors
  assign stat.valid = valid;
  assign stat.up    = valid && (val > sample);
  assign stat.down  = full && valid && (val > old_sample);
  assign stat.eq    = full && valid && (val == old_sample);

  // Evicted copy is the highest cell equal to the old sample
  assign removed      = stat.eq && !right_stat.eq;
  assign left_removed = left_stat.eq && !stat.eq;
  assign stays        = valid && !removed && (stat.up == stat.down);

  // Pick from right neighbor, left neighbor, self, or take the new sample
  always_comb begin
    if (right_stat.down && !right_stat.up) begin
      val_next = right_val;
    end else if (left_stat.up && !left_stat.down && !left_removed) begin
      val_next = left_val;
    end else if (stays) begin
      val_next = val;
    end else begin
      val_next = sample;
    end
    valid_next = full ? valid : (valid || left_stat.valid);
  end

  always_ff @(posedge clk) begin
    if (rst || clear) begin
      valid <= 1'b0;
    end else if (step) begin
      valid <= valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      val <= val_next;
    end
  end

endmodule

@@ hw/rtl/sliding_window_median_core.sv @@
`timescale 1ns / 1ps

// Running median filter over the last window_size signed 32-bit samples.
// sample_chan: one sample per beat (valid/ready). median_chan: one lower
// median per beat, given for each sample once the window is full; while
// the window fills no beat is produced.
// cfg: one window_size write per beat (always ready); write it only while
// the block is idle, since it empties the window. 0 acts as 1, values above
// WINDOW_MAX act as WINDOW_MAX.
// Timing: a sample is accepted in the idle state (ST_IDLE); the ring buffer
// read of the oldest slot returns in the next cycle (ST_UPD), the sorted cell
// row updates in that cycle, and in ST_RES the rank select loads the output
// register once it is free. A new sample is taken only after the last one has
// passed ST_UPD and ST_RES.
// Reset clears the fill count, the cell valid bits and sets window_size
// to 3. A stalled receiver holds the result in the output register; the
// next sample is still taken and its result waits until the register frees.
module sliding_window_median_core #(
  parameter int WINDOW_MAX = 64
) (
  input  logic         clk,
  input  logic         rst,
  swm_cfg_if.sink      cfg,
  swm_sample_if.sink   sample_chan,
  swm_median_if.source median_chan
);

  localparam int AW = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
  localparam int CW = $clog2(WINDOW_MAX + 1);
  localparam logic [CW-1:0] WMAX = CW'(WINDOW_MAX);
  localparam logic [CW-1:0] ONE  = CW'(1);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_UPD  = 2'd1;
  localparam logic [1:0] ST_RES  = 2'd2;

  logic [1:0]              state;
  logic [1:0]              state_next;
  swm_pkg::wsize_t         window_size;
  logic [CW-1:0]           fill;
  logic [AW-1:0]           oldest;
  swm_pkg::sample_t        cur;
  swm_pkg::sample_t        old_sample;
  logic [CW-1:0]           eff_w;
  logic [CW-1:0]           mid;
  logic                    full;
  logic                    accept;
  logic                    cfg_wr;
  logic                    step;
  logic                    load_out;
  logic [AW-1:0]           wr_addr;
  logic                    out_valid;
  swm_pkg::sample_t        out_data;

  swm_pkg::cell_stat_t     stat [WINDOW_MAX];
  swm_pkg::sample_t        cval [WINDOW_MAX];

  assign cfg.ready          = 1'b1;
  assign cfg_wr             = cfg.valid;
  assign sample_chan.ready  = (state == ST_IDLE);
  assign accept             = sample_chan.valid && (state == ST_IDLE);
  assign step               = (state == ST_UPD);
  assign median_chan.valid  = out_valid;
  assign median_chan.median = out_data;

  // Effective window: 0 acts as 1, saturate at WINDOW_MAX
  always_comb begin
    if (window_size == '0) begin
      eff_w = ONE;
    end else if (32'(window_size) > 32'(WINDOW_MAX)) begin
      eff_w = WMAX;
    end else begin
      eff_w = CW'(window_size);
    end
    mid  = (eff_w - ONE) >> 1;
    full = (fill == eff_w);
  end

  // Ring buffer of arrival order
  assign wr_addr = full ? oldest : fill[AW-1:0];

  swm_ram #(
    .WIDTH (swm_pkg::SAMPLE_W),
    .DEPTH (WINDOW_MAX)
  ) u_ring (
    .clk     (clk),
    .wr_en   (step),
    .wr_addr (wr_addr),
    .wr_data (cur),
    .rd_addr (oldest),
    .rd_data (old_sample)
  );

  // Sorted row of cells
  for (genvar j = 0; j < WINDOW_MAX; j++) begin : g_cell
    swm_pkg::cell_stat_t lstat;
    swm_pkg::cell_stat_t rstat;
    swm_pkg::sample_t    lval;
    swm_pkg::sample_t    rval;

    if (j == 0) begin : g_first
      // valid high so the first sample lands in cell 0
      assign lstat = '{valid: 1'b1, up: 1'b0, down: 1'b0, eq: 1'b0};
      assign lval  = cur;
    end else begin : g_mid_l
      assign lstat = stat[j-1];
      assign lval  = cval[j-1];
    end

    if (j == WINDOW_MAX - 1) begin : g_last
      assign rstat = '0;
      assign rval  = cur;
    end else begin : g_mid_r
      assign rstat = stat[j+1];
      assign rval  = cval[j+1];
    end

    swm_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .clear      (cfg_wr),
      .step       (step),
      .full       (full),
      .sample     (cur),
      .old_sample (old_sample),
      .left_stat  (lstat),
      .left_val   (lval),
      .right_stat (rstat),
      .right_val  (rval),
      .stat       (stat[j]),
      .val        (cval[j])
    );
  end

  // Sequencer
  always_comb begin
    state_next = state;
    load_out   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          state_next = ST_UPD;
        end
      end
      ST_UPD: begin
        state_next = ST_RES;
      end
      ST_RES: begin
        if (!full) begin
          state_next = ST_IDLE;
        end else if (!out_valid || median_chan.ready) begin
          load_out   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Window size, fill count and oldest slot
  always_ff @(posedge clk) begin
    if (rst) begin
      window_size <= swm_pkg::WSIZE_RESET;
      fill        <= '0;
      oldest      <= '0;
    end else if (cfg_wr) begin
      window_size <= cfg.window_size;
      fill        <= '0;
      oldest      <= '0;
    end else if (step) begin
      if (full) begin
        if ((CW'(oldest) + ONE) == eff_w) begin
          oldest <= '0;
        end else begin
          oldest <= oldest + AW'(1);
        end
      end else begin
        fill <= fill + ONE;
      end
    end
  end

  // Sample being processed
  always_ff @(posedge clk) begin
    if (accept) begin
      cur <= sample_chan.sample;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (median_chan.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_data <= cval[mid[AW-1:0]];
    end
  end

endmodule

@@ tb/sliding_window_median_core_tb.sv @@
`timescale 1ns / 1ps

module sliding_window_median_core_tb;

  localparam int WIN_MAX = 64;
  localparam int GAP_PCT = 6;
  localparam int HOLD_CYCLES = 120;
  localparam int SETTLE_CYCLES = 8;

  logic clk;
  logic rst;

  swm_cfg_if    cfg_bus ();
  swm_sample_if sample_bus ();
  swm_median_if median_bus ();

  sliding_window_median_core dut (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg_bus),
    .sample_chan (sample_bus),
    .median_chan (median_bus)
  );

  // Samples waiting for the driver, medians waiting for the monitor
  swm_pkg::sample_t pending_samples[$];
  swm_pkg::sample_t median_expected[$];

  // Predictor state: written window size and window contents in arrival order
  swm_pkg::wsize_t  window_size_q;
  swm_pkg::sample_t recent_window[$];

  bit sample_taken;
  bit no_gaps;
  int hold_asked;
  int errors;

  // Clock
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Run limit
  initial begin
    #3000000;
    $display("sliding_window_median_core_tb NOT OK");
    $finish;
  end

  // Window length the block really uses: 0 acts as 1, large values saturate
  function automatic int unsigned active_len(input swm_pkg::wsize_t ws);
    if (ws == '0) return 1;
    if (int'(ws) > WIN_MAX) return WIN_MAX;
    return int'(ws);
  endfunction

  // Push one sample into the predicted window; queue the lower median once full
  task automatic predict_median(input swm_pkg::sample_t s);
    int unsigned w;
    int unsigned i;
    swm_pkg::sample_t ordered[$];
    w = active_len(window_size_q);
    recent_window.push_back(s);
    if (recent_window.size() > w) void'(recent_window.pop_front());
    if (recent_window.size() == w) begin
      foreach (recent_window[k]) begin
        i = 0;
        while (i < ordered.size() && ordered[i] <= recent_window[k]) i++;
        ordered.insert(i, recent_window[k]);
      end
      median_expected.push_back(ordered[(w - 1) / 2]);
    end
  endtask

  // Mix of extremes, tight clusters for duplicates and full-range values
  function automatic swm_pkg::sample_t rand_sample();
    case ($urandom_range(9))
      0: return swm_pkg::sample_t'(32'h7FFF_FFFF);
      1: return swm_pkg::sample_t'(32'h8000_0000);
      2, 3: return swm_pkg::sample_t'(int'($urandom_range(8)) - 4);
      default: return swm_pkg::sample_t'($urandom);
    endcase
  endfunction

  // Input side: record accepted beats and predict
  always @(posedge clk) begin
    if (!rst && sample_bus.valid && sample_bus.ready) begin
      predict_median(sample_bus.sample);
      sample_taken = 1'b1;
    end
  end

  // Sample driver: next beat from the pending queue, random gaps
  always @(negedge clk) begin
    if (!sample_bus.valid || sample_taken) begin
      if (pending_samples.size() > 0 && (no_gaps || $urandom_range(99) >= GAP_PCT)) begin
        sample_bus.valid  <= 1'b1;
        sample_bus.sample <= pending_samples.pop_front();
      end else begin
        sample_bus.valid <= 1'b0;
      end
    end
    sample_taken = 1'b0;
  end

  // Receiver ready: random stalls plus an occasional long hold-off
  int hold_done = 0;
  int hold_left = 0;
  always @(negedge clk) begin
    if (hold_asked != hold_done) begin
      hold_done = hold_asked;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      median_bus.ready <= 1'b0;
    end else begin
      median_bus.ready <= no_gaps || $urandom_range(99) >= GAP_PCT;
    end
  end

  // Output monitor: compare each median beat with the oldest expectation
  always @(posedge clk) begin
    if (!rst && median_bus.valid && median_bus.ready) begin
      if (median_expected.size() == 0) begin
        $error("median: unexpected beat, value %0d", median_bus.median);
        errors++;
      end else begin
        swm_pkg::sample_t exp_median;
        exp_median = median_expected.pop_front();
        if (median_bus.median !== exp_median) begin
          $error("median: expected %0d, got %0d", exp_median, median_bus.median);
          errors++;
        end
      end
    end
  end

  // Window size write; the block empties its window on it
  task automatic write_window(input swm_pkg::wsize_t ws);
    @(negedge clk);
    cfg_bus.valid       <= 1'b1;
    cfg_bus.window_size <= ws;
    do @(posedge clk); while (!cfg_bus.ready);
    window_size_q = ws;
    recent_window.delete();
    @(negedge clk);
    cfg_bus.valid <= 1'b0;
  endtask

  // Wait for all beats to drain, then let the pipeline settle
  task automatic wait_idle();
    do @(posedge clk);
    while (pending_samples.size() != 0 || sample_bus.valid || median_expected.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic run_random(input swm_pkg::wsize_t ws, input int n);
    write_window(ws);
    repeat (n) pending_samples.push_back(rand_sample());
    wait_idle();
  endtask

  // Stimulus
  initial begin
    rst                   = 1'b1;
    cfg_bus.valid         = 1'b0;
    cfg_bus.window_size   = swm_pkg::WSIZE_RESET;
    sample_bus.valid      = 1'b0;
    sample_bus.sample     = '0;
    median_bus.ready      = 1'b0;
    window_size_q         = swm_pkg::WSIZE_RESET;
    sample_taken          = 1'b0;
    no_gaps               = 1'b0;
    hold_asked            = 0;
    errors                = 0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Reset window of 3: extremes, then duplicates of the minimum
    pending_samples = '{swm_pkg::sample_t'(32'h7FFF_FFFF), swm_pkg::sample_t'(32'h8000_0000),
                        swm_pkg::sample_t'(0), swm_pkg::sample_t'(-1),
                        swm_pkg::sample_t'(1), swm_pkg::sample_t'(32'h8000_0000),
                        swm_pkg::sample_t'(32'h8000_0000)};
    wait_idle();

    // Size 0 behaves as 1: every sample is its own median
    write_window(swm_pkg::wsize_t'(0));
    pending_samples = '{swm_pkg::sample_t'(32'h7FFF_FFFF), swm_pkg::sample_t'(32'h8000_0000),
                        swm_pkg::sample_t'(5)};
    wait_idle();

    // Even window: lower of the two middle values
    write_window(swm_pkg::wsize_t'(2));
    pending_samples = '{swm_pkg::sample_t'(10), swm_pkg::sample_t'(-10),
                        swm_pkg::sample_t'(10), swm_pkg::sample_t'(10)};
    wait_idle();

    // Duplicates around the median rank
    write_window(swm_pkg::wsize_t'(4));
    pending_samples = '{swm_pkg::sample_t'(3), swm_pkg::sample_t'(3), swm_pkg::sample_t'(3),
                        swm_pkg::sample_t'(-3), swm_pkg::sample_t'(3)};
    wait_idle();

    // Oversized setting saturates to the full window
    run_random(swm_pkg::wsize_t'(127), 140);
    run_random(swm_pkg::wsize_t'(65), 90);

    // Full window, no gaps on either side
    no_gaps = 1'b1;
    run_random(swm_pkg::wsize_t'(WIN_MAX), 100);
    no_gaps = 1'b0;

    // Long receiver hold-off while samples keep coming
    write_window(swm_pkg::wsize_t'(1));
    hold_asked++;
    repeat (60) pending_samples.push_back(rand_sample());
    wait_idle();

    repeat (8) run_random(swm_pkg::wsize_t'($urandom_range(1, 20)), $urandom_range(15, 40));
    run_random(swm_pkg::wsize_t'(0), 20);

    if (median_expected.size() != 0) begin
      $error("median: %0d expected beats never arrived", median_expected.size());
      errors++;
    end
    if (errors == 0) begin
      $display("sliding_window_median_core_tb OK");
    end else begin
      $display("sliding_window_median_core_tb NOT OK");
    end
    $finish;
  end

endmodule
